>>> rtl/assert_macros.svh
// Assertion macros shared by the TCP receive checker RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked from one edge to the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication checked at the same edge.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/tsc_pkg.sv
// Shared types, constants and one's-complement helpers for the TCP receive checker.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

   localparam int HEADER_BYTES = 20;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 64;

   localparam logic [3:0]  OFFSET_MIN   = 4'd5;
   localparam logic [7:0]  FLAGS_MASK   = 8'h3F;
   localparam logic [15:0] TCP_PROTOCOL = 16'd6;
   localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IP_MODE  = 3'd0,
      CSR_SRC_HIGH = 3'd1,
      CSR_SRC_LOW  = 3'd2,
      CSR_DST_HIGH = 3'd3,
      CSR_DST_LOW  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_SHORT      = 2'd1,
      ST_BAD_OFFSET = 2'd2,
      ST_BEYOND     = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [31:0] sequence_number;
      logic [31:0] ack_number;
      logic [5:0]  tcp_flags;
      logic [15:0] window_size;
      logic [15:0] header_checksum;
      logic [15:0] urgent_ptr;
      logic [5:0]  header_length;
      logic [1:0]  parse_status;
      logic        checksum_valid;
   } rsp_payload_type;

   typedef struct packed {
      logic        ip_v6;
      logic [63:0] src_high;
      logic [63:0] src_low;
      logic [63:0] dst_high;
      logic [63:0] dst_low;
   } cfg_type;

   // One finished segment handed from the byte front end to the result stage.
   typedef struct packed {
      logic [15:0]                   data_sum;
      logic [31:0]                   byte_count;
      logic [HEADER_BYTES-1:0][7:0] header;
   } seg_rec_type;

   // Two-operand one's-complement add with end-around carry.
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + 16'(s[16]);
   endfunction

   // Folds a sum of up to eight 16-bit words back into one's-complement form.
   function automatic logic [15:0] fold19(input logic [18:0] s);
      logic [16:0] t;
      t = {1'b0, s[15:0]} + 17'(s[18:16]);
      return t[15:0] + 16'(t[16]);
   endfunction

   // Sum of the 16-bit words of a 64-bit address part; the upper half only when enabled.
   function automatic logic [15:0] addr_sum(input logic [63:0] v, input logic upper_en);
      logic [18:0] s;
      s = 19'(v[15:0]) + 19'(v[31:16]);
      if (upper_en) begin
         s = s + 19'(v[47:32]) + 19'(v[63:48]);
      end
      return fold19(s);
   endfunction

endpackage

`default_nettype wire

>>> rtl/tsc_front.sv
// Byte front end: running one's-complement sum, byte count and header capture.
// Depends on tsc_pkg; pushes one record per segment into tsc_queue.
`timescale 1ns / 1ps
`default_nettype none

module tsc_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire tsc_pkg::req_payload_type  req_payload,
   output logic                           push_valid,
   input  wire logic                      push_ready,
   output tsc_pkg::seg_rec_type           push_data
);

   logic [15:0]                            sum_ff, sum_in;
   logic [7:0]                             hold_ff, hold_in;
   logic                                   odd_ff, odd_in;
   logic [31:0]                            count_ff, count_in;
   logic [tsc_pkg::HEADER_BYTES-1:0][7:0] hdr_ff, hdr_in;
   logic [15:0]                            word;
   logic [15:0]                            sum_add;
   logic [31:0]                            count_next;
   logic                                   accept;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   // A byte in the even position becomes the high half, padded with zero
   // in case the segment ends on it.
   assign word       = odd_ff ? {hold_ff, req_payload.byte_value}
                              : {req_payload.byte_value, 8'h00};
   assign sum_add    = tsc_pkg::oc_add(sum_ff, word);
   assign count_next = (&count_ff) ? count_ff : count_ff + 32'd1;

   always_comb begin
      hdr_in = hdr_ff;
      for (int i = 0; i < tsc_pkg::HEADER_BYTES; i++) begin
         if (count_ff == 32'(i)) begin
            hdr_in[i] = req_payload.byte_value;
         end
      end
   end

   always_comb begin
      sum_in   = sum_ff;
      hold_in  = hold_ff;
      odd_in   = odd_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_payload.last_byte) begin
            sum_in   = '0;
            hold_in  = '0;
            odd_in   = 1'b0;
            count_in = '0;
         end else begin
            count_in = count_next;
            if (odd_ff) begin
               sum_in = sum_add;
               odd_in = 1'b0;
            end else begin
               hold_in = req_payload.byte_value;
               odd_in  = 1'b1;
            end
         end
      end
   end

   assign push_valid           = req_valid && req_payload.last_byte;
   assign push_data.data_sum   = sum_add;
   assign push_data.byte_count = count_next;
   assign push_data.header     = hdr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         hold_ff  <= '0;
         odd_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         hold_ff  <= hold_in;
         odd_ff   <= odd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff <= hdr_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/tsc_queue.sv
// Short queue of segment records between the byte front end and the result stage.
// Depends on tsc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tsc_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   output logic                       push_ready,
   input  wire tsc_pkg::seg_rec_type  push_data,
   output logic                       pop_valid,
   input  wire logic                  pop_ready,
   output tsc_pkg::seg_rec_type       pop_data
);

   tsc_pkg::seg_rec_type              entry_ff [tsc_pkg::QUEUE_DEPTH];
   logic [tsc_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [tsc_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [tsc_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              push;
   logic                              pop;

   assign push_ready = (count_ff != tsc_pkg::QCNT_W'(tsc_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tsc_pkg::QPTR_W'(tsc_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tsc_pkg::QPTR_W'(tsc_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= tsc_pkg::QCNT_W'(tsc_pkg::QUEUE_DEPTH), "queue count beyond depth")
   `ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "push without pop did not grow the queue")
   `ASSERT_SAME(a_empty_ptrs, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "empty queue with pointers apart")

endmodule

`default_nettype wire

>>> rtl/tsc_back.sv
// Result stage: pseudo-header sum, header parse and the registered result.
// Depends on tsc_pkg and assert_macros.svh; fed by tsc_queue.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tsc_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire tsc_pkg::cfg_type          cfg,
   input  wire logic                      pop_valid,
   output logic                           pop_ready,
   input  wire tsc_pkg::seg_rec_type      pop_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output tsc_pkg::rsp_payload_type       rsp_payload
);

   typedef struct packed {
      logic [15:0]              src_high_sum;
      logic [15:0]              src_low_sum;
      logic [15:0]              dst_high_sum;
      logic [15:0]              dst_low_sum;
      logic [15:0]              data_sum;
      logic                     long_enough;
      tsc_pkg::rsp_payload_type fields;
   } stage_type;

   stage_type                         s1_ff, s1_in;
   logic                              s1_valid_ff, s1_valid_in;
   logic                              s1_ready;
   tsc_pkg::rsp_payload_type          out_ff, out_in;
   logic                              out_valid_ff, out_valid_in;
   logic                              out_ready;
   logic [tsc_pkg::HEADER_BYTES-1:0][7:0] hdr;
   logic [31:0]                       len;
   logic [3:0]                        offs;
   logic [5:0]                        hlen;
   logic [18:0]                       data_raw;
   logic [18:0]                       total_raw;
   logic [15:0]                       total;

   assign out_ready = !out_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign pop_ready = s1_ready;

   assign hdr  = pop_data.header;
   assign len  = pop_data.byte_count;
   assign offs = hdr[12][7:4];
   assign hlen = {offs, 2'b00};

   // The IPv6 pseudo-header carries the full 32-bit length, IPv4 only its low half.
   assign data_raw = 19'(pop_data.data_sum) + 19'(len[15:0]) + 19'(tsc_pkg::TCP_PROTOCOL)
                   + (cfg.ip_v6 ? 19'(len[31:16]) : 19'd0);

   always_comb begin
      s1_in = '0;
      s1_in.src_high_sum = tsc_pkg::addr_sum(cfg.ip_v6 ? cfg.src_high : 64'd0, 1'b1);
      s1_in.dst_high_sum = tsc_pkg::addr_sum(cfg.ip_v6 ? cfg.dst_high : 64'd0, 1'b1);
      s1_in.src_low_sum  = tsc_pkg::addr_sum(cfg.src_low, cfg.ip_v6);
      s1_in.dst_low_sum  = tsc_pkg::addr_sum(cfg.dst_low, cfg.ip_v6);
      s1_in.data_sum     = tsc_pkg::fold19(data_raw);
      s1_in.long_enough  = (len >= 32'(tsc_pkg::HEADER_BYTES));
      if (!s1_in.long_enough) begin
         s1_in.fields.parse_status = tsc_pkg::ST_SHORT;
      end else if (offs < tsc_pkg::OFFSET_MIN) begin
         s1_in.fields.parse_status = tsc_pkg::ST_BAD_OFFSET;
      end else if (32'(hlen) > len) begin
         s1_in.fields.parse_status = tsc_pkg::ST_BEYOND;
      end else begin
         s1_in.fields.parse_status    = tsc_pkg::ST_OK;
         s1_in.fields.source_port     = {hdr[0], hdr[1]};
         s1_in.fields.dest_port       = {hdr[2], hdr[3]};
         s1_in.fields.sequence_number = {hdr[4], hdr[5], hdr[6], hdr[7]};
         s1_in.fields.ack_number      = {hdr[8], hdr[9], hdr[10], hdr[11]};
         s1_in.fields.tcp_flags       = 6'(hdr[13] & tsc_pkg::FLAGS_MASK);
         s1_in.fields.window_size     = {hdr[14], hdr[15]};
         s1_in.fields.header_checksum = {hdr[16], hdr[17]};
         s1_in.fields.urgent_ptr      = {hdr[18], hdr[19]};
         s1_in.fields.header_length   = hlen;
      end
   end

   assign total_raw = 19'(s1_ff.src_high_sum) + 19'(s1_ff.src_low_sum)
                    + 19'(s1_ff.dst_high_sum) + 19'(s1_ff.dst_low_sum)
                    + 19'(s1_ff.data_sum);
   assign total     = tsc_pkg::fold19(total_raw);

   always_comb begin
      out_in                = s1_ff.fields;
      out_in.checksum_valid = (total == tsc_pkg::SUM_ALL_ONES) && s1_ff.long_enough;
   end

   assign s1_valid_in  = s1_ready ? pop_valid : s1_valid_ff;
   assign out_valid_in = out_ready ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (out_ready) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   `ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && !s1_ready, s1_valid_ff && $stable(s1_ff), "stalled sum stage lost its segment")

endmodule

`default_nettype wire

>>> rtl/tcp_segment_rx_check.sv
// Top level of the TCP receive checker: configuration registers and the three parts.
// Depends on tsc_pkg, tsc_front, tsc_queue and tsc_back.
//
//   Port group   Direction   Handshake          Moves
//   req_*        in          valid / ready      one segment byte per request
//   rsp_*        out         valid / ready      one parsed result per segment
//   csr_*        in          write enable only  address and protocol registers
//
// One byte is taken every cycle while the record queue has room.
// A segment's record passes through the queue and the sum stage before its result is registered.
// The two-entry record queue and the registered result let bytes keep flowing
// while a result waits for rsp_ready; a full queue drops req_ready.
// Synchronous reset clears the registers, the running sum and the queue.
`timescale 1ns / 1ps
`default_nettype none

module tcp_segment_rx_check (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire tsc_pkg::req_payload_type            req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output tsc_pkg::rsp_payload_type                 rsp_payload,
   input  wire logic                                csr_wr_en,
   input  wire logic [tsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [tsc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   tsc_pkg::cfg_type      cfg_ff, cfg_in;
   logic                  push_valid;
   logic                  push_ready;
   tsc_pkg::seg_rec_type  push_data;
   logic                  pop_valid;
   logic                  pop_ready;
   tsc_pkg::seg_rec_type  pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tsc_pkg::CSR_IP_MODE:  cfg_in.ip_v6    = csr_wdata[0];
            tsc_pkg::CSR_SRC_HIGH: cfg_in.src_high = csr_wdata;
            tsc_pkg::CSR_SRC_LOW:  cfg_in.src_low  = csr_wdata;
            tsc_pkg::CSR_DST_HIGH: cfg_in.dst_high = csr_wdata;
            tsc_pkg::CSR_DST_LOW:  cfg_in.dst_low  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   tsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tsc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> tb/tcp_segment_rx_check_test.sv
// Self-checking testbench for tcp_segment_rx_check: random segments, stalls, register phases.
// Depends on tsc_pkg and the tcp_segment_rx_check RTL; needs nothing else.
`timescale 1ns / 1ps

module tcp_segment_rx_check_test;

   localparam int unsigned CYCLE_LIMIT  = 200_000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam logic [tsc_pkg::CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   tsc_pkg::req_payload_type       req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   tsc_pkg::rsp_payload_type       rsp_payload;
   logic                           csr_wr_en = 1'b0;
   logic [tsc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tsc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   tcp_segment_rx_check u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Our copy of the registers and of the per-segment state.
   tsc_pkg::cfg_type addr_cfg = '0;
   logic [15:0]      seg_sum = '0;
   logic [7:0]       hold_byte = '0;
   logic             odd_byte = 1'b0;
   logic [31:0]      seg_count = '0;
   logic [7:0]       hdr_bytes [tsc_pkg::HEADER_BYTES];

   tsc_pkg::req_payload_type bytes_to_send [$];
   tsc_pkg::rsp_payload_type results_due [$];
   int unsigned     mismatch_count = 0;
   int unsigned     cycle_count = 0;

   int unsigned     burst_left = 0;
   int unsigned     gap_left = 0;
   int unsigned     hold_left = 0;
   int unsigned     hold_cooldown = 0;
   int unsigned     stall_mode = 0;
   int unsigned     mode_left = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
      logic [16:0] s;
      s = {1'b0, acc} + {1'b0, word};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // Adds the pseudo-header for the current address mode to a partial sum.
   function automatic logic [15:0] pseudo_header_sum(input logic [15:0] acc,
                                                     input logic [31:0] seg_len);
      logic [63:0] parts [4];
      logic [15:0] s;
      s = acc;
      if (addr_cfg.ip_v6) begin
         parts[0] = addr_cfg.src_high;
         parts[1] = addr_cfg.src_low;
         parts[2] = addr_cfg.dst_high;
         parts[3] = addr_cfg.dst_low;
         for (int p = 0; p < 4; p++) begin
            for (int w = 3; w >= 0; w--) begin
               s = ones_add(s, parts[p][16*w +: 16]);
            end
         end
         s = ones_add(s, seg_len[31:16]);
         s = ones_add(s, seg_len[15:0]);
         s = ones_add(s, tsc_pkg::TCP_PROTOCOL);
      end else begin
         s = ones_add(s, addr_cfg.src_low[31:16]);
         s = ones_add(s, addr_cfg.src_low[15:0]);
         s = ones_add(s, addr_cfg.dst_low[31:16]);
         s = ones_add(s, addr_cfg.dst_low[15:0]);
         s = ones_add(s, tsc_pkg::TCP_PROTOCOL);
         s = ones_add(s, seg_len[15:0]);
      end
      return s;
   endfunction

   // Folds one accepted byte into the segment state; the marked byte yields a parsed header.
   task automatic track_request_byte(input tsc_pkg::req_payload_type item);
      logic [15:0]              total;
      logic [3:0]               offs;
      logic [31:0]              hlen;
      tsc_pkg::status_type      status;
      tsc_pkg::rsp_payload_type want;
      if (seg_count < tsc_pkg::HEADER_BYTES) begin
         hdr_bytes[seg_count] = item.byte_value;
      end
      if (odd_byte) begin
         seg_sum = ones_add(seg_sum, {hold_byte, item.byte_value});
         odd_byte = 1'b0;
      end else begin
         hold_byte = item.byte_value;
         odd_byte = 1'b1;
      end
      if (seg_count != 32'hFFFF_FFFF) begin
         seg_count = seg_count + 32'd1;
      end
      if (item.last_byte) begin
         // An odd trailing byte is padded with a zero low byte.
         total = odd_byte ? ones_add(seg_sum, {hold_byte, 8'h00}) : seg_sum;
         total = pseudo_header_sum(total, seg_count);
         want = '0;
         if (seg_count < tsc_pkg::HEADER_BYTES) begin
            status = tsc_pkg::ST_SHORT;
         end else begin
            offs = hdr_bytes[12][7:4];
            hlen = {26'd0, offs, 2'b00};
            if (offs < tsc_pkg::OFFSET_MIN) begin
               status = tsc_pkg::ST_BAD_OFFSET;
            end else if (hlen > seg_count) begin
               status = tsc_pkg::ST_BEYOND;
            end else begin
               status = tsc_pkg::ST_OK;
               want.source_port     = {hdr_bytes[0], hdr_bytes[1]};
               want.dest_port       = {hdr_bytes[2], hdr_bytes[3]};
               want.sequence_number = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
               want.ack_number      = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
               want.tcp_flags       = hdr_bytes[13][5:0];
               want.window_size     = {hdr_bytes[14], hdr_bytes[15]};
               want.header_checksum = {hdr_bytes[16], hdr_bytes[17]};
               want.urgent_ptr      = {hdr_bytes[18], hdr_bytes[19]};
               want.header_length   = hlen[5:0];
            end
         end
         want.parse_status   = status;
         want.checksum_valid = (total == tsc_pkg::SUM_ALL_ONES)
                               && (seg_count >= tsc_pkg::HEADER_BYTES);
         results_due.push_back(want);
         seg_sum   = '0;
         hold_byte = '0;
         odd_byte  = 1'b0;
         seg_count = '0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at cycle %0d: %s: got %0h, expected %0h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [63:0] got, input logic [63:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   task automatic check_result(input tsc_pkg::rsp_payload_type got);
      tsc_pkg::rsp_payload_type want;
      want = results_due.pop_front();
      check_field("source_port", got.source_port, want.source_port);
      check_field("dest_port", got.dest_port, want.dest_port);
      check_field("sequence_number", got.sequence_number, want.sequence_number);
      check_field("ack_number", got.ack_number, want.ack_number);
      check_field("tcp_flags", got.tcp_flags, want.tcp_flags);
      check_field("window_size", got.window_size, want.window_size);
      check_field("header_checksum", got.header_checksum, want.header_checksum);
      check_field("urgent_ptr", got.urgent_ptr, want.urgent_ptr);
      check_field("header_length", got.header_length, want.header_length);
      check_field("parse_status", got.parse_status, want.parse_status);
      check_field("checksum_valid", got.checksum_valid, want.checksum_valid);
   endtask

   // Builds one segment; with fix_sum and at least 18 bytes the checksum field is set so the sum verifies.
   task automatic queue_segment(input int unsigned seg_len, input logic [3:0] offset_nib,
                                input bit fix_sum, input bit random_fill,
                                input logic [7:0] fill_value);
      logic [7:0]               seg [];
      logic [15:0]              acc;
      tsc_pkg::req_payload_type item;
      seg = new[seg_len];
      foreach (seg[i]) begin
         seg[i] = random_fill ? 8'($urandom) : fill_value;
      end
      if (seg_len > 12) begin
         seg[12] = {offset_nib, seg[12][3:0]};
      end
      if (fix_sum && seg_len >= 18) begin
         seg[16] = 8'h00;
         seg[17] = 8'h00;
         acc = 16'h0000;
         for (int unsigned i = 0; i < seg_len; i += 2) begin
            acc = ones_add(acc, {seg[i], (i + 1 < seg_len) ? seg[i+1] : 8'h00});
         end
         acc = pseudo_header_sum(acc, 32'(seg_len));
         {seg[16], seg[17]} = ~acc;
      end
      foreach (seg[i]) begin
         item.byte_value = seg[i];
         item.last_byte  = (i == seg_len - 1);
         bytes_to_send.push_back(item);
      end
   endtask

   // Mostly well-formed segments, the rest short, with a bad offset or a header past the end.
   task automatic queue_random_segment(output int unsigned seg_len);
      int unsigned pick;
      int unsigned hlen;
      logic [3:0]  offs;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         offs = 4'($urandom);
         seg_len = $urandom_range(1, tsc_pkg::HEADER_BYTES - 1);
      end else if (pick < 20) begin
         offs = 4'($urandom_range(0, 4));
         seg_len = $urandom_range(tsc_pkg::HEADER_BYTES, 40);
      end else if (pick < 28) begin
         offs = 4'($urandom_range(6, 15));
         hlen = 4 * offs;
         seg_len = $urandom_range(tsc_pkg::HEADER_BYTES, hlen - 1);
      end else begin
         offs = ($urandom_range(0, 1) != 0) ? 4'd5 : 4'($urandom_range(5, 15));
         hlen = 4 * offs;
         seg_len = $urandom_range(hlen, hlen + 30);
      end
      queue_segment(seg_len, offs, $urandom_range(0, 3) != 0, 1'b1, 8'h00);
   endtask

   task automatic queue_random_bytes(input int unsigned budget);
      int unsigned queued;
      int unsigned n;
      queued = 0;
      while (queued < budget) begin
         queue_random_segment(n);
         queued += n;
      end
   endtask

   task automatic csr_write(input logic [tsc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         tsc_pkg::CSR_IP_MODE:  addr_cfg.ip_v6    = data[0];
         tsc_pkg::CSR_SRC_HIGH: addr_cfg.src_high = data;
         tsc_pkg::CSR_SRC_LOW:  addr_cfg.src_low  = data;
         tsc_pkg::CSR_DST_HIGH: addr_cfg.dst_high = data;
         tsc_pkg::CSR_DST_LOW:  addr_cfg.dst_low  = data;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_settings(input logic v6, input logic [63:0] src_high,
                                 input logic [63:0] src_low, input logic [63:0] dst_high,
                                 input logic [63:0] dst_low);
      // Upper bits of the mode word are noise; only bit 0 selects the family.
      csr_write(tsc_pkg::CSR_IP_MODE, {$urandom, $urandom} & ~64'd1 | {63'd0, v6});
      csr_write(tsc_pkg::CSR_SRC_HIGH, src_high);
      csr_write(tsc_pkg::CSR_SRC_LOW, src_low);
      csr_write(tsc_pkg::CSR_DST_HIGH, dst_high);
      csr_write(tsc_pkg::CSR_DST_LOW, dst_low);
      @(negedge clock);
   endtask

   task automatic wait_drained;
      do begin
         @(negedge clock);
      end while (bytes_to_send.size() != 0 || req_valid || results_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (bytes_to_send.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            req_payload <= bytes_to_send.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                                         : $urandom_range(20, 300);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Receiver: changing stall modes, plus a long hold-off when plenty of bytes wait and the
   // cooldown has run out, so that the block fills its queue and drops req_ready.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_cooldown == 0 && bytes_to_send.size() > 200) begin
         hold_left = 400;
         hold_cooldown = 3000;
         rsp_ready <= 1'b0;
      end else begin
         if (hold_cooldown != 0) begin
            hold_cooldown--;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(16, 160);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            track_request_byte(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               report_mismatch("result with no request pending", 64'(rsp_payload.parse_status),
                               64'd0);
            end else begin
               check_result(rsp_payload);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tcp_segment_rx_check_test: errors");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // IPv4 with noise in the unused address bits; short directed segments first.
      apply_settings(1'b0, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
      queue_segment(1, 4'hF, 1'b0, 1'b0, 8'hFF);
      queue_segment(tsc_pkg::HEADER_BYTES, 4'd5, 1'b1, 1'b0, 8'hFF);
      queue_segment(3, 4'h0, 1'b0, 1'b0, 8'h00);
      queue_random_bytes(350);
      wait_drained();

      apply_settings(1'b1, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
      queue_random_bytes(350);
      wait_drained();

      // All-zero addresses; a write to an unmapped index must change nothing.
      apply_settings(1'b0, '0, '0, '0, '0);
      csr_write(CSR_UNMAPPED, {$urandom, $urandom});
      @(negedge clock);
      queue_random_bytes(130);
      wait_drained();

      apply_settings(1'b1, '1, '1, '1, '1);
      queue_random_bytes(130);
      wait_drained();

      // Every address bit set under IPv4, where only the low 32 bits of each low register count.
      apply_settings(1'b0, '1, '1, '1, '1);
      queue_random_bytes(100);
      wait_drained();

      apply_settings(1'b1, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
      queue_random_bytes(130);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("tcp_segment_rx_check_test: clean");
      end else begin
         $display("tcp_segment_rx_check_test: errors");
      end
      $finish;
   end

endmodule
